/* rtl/calendar_minute_clock_assert.svh */
// Assertion macros used by the calendar clock top level.
`ifndef CALENDAR_MINUTE_CLOCK_ASSERT_SVH
`define CALENDAR_MINUTE_CLOCK_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CMC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("calendar clock assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CMC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("calendar clock assertion failed");

// Next-cycle implication that is also checked across reset.
`define CMC_ASSERT_RESET(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("calendar clock assertion failed");

`endif

/* rtl/cmc_pkg.sv */
// Types, constants and month-length lookup for the calendar minute clock.
package cmc_pkg;

   // Command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // Field limits and reset values
   localparam logic [13:0] YEAR_MAX    = 14'd9999;
   localparam logic [13:0] YEAR_RESET  = 14'd2019;
   localparam logic [3:0]  MONTH_FIRST = 4'd1;
   localparam logic [3:0]  MONTH_FEB   = 4'd2;
   localparam logic [3:0]  MONTH_MAX   = 4'd12;
   localparam logic [4:0]  DAY_FIRST   = 5'd1;
   localparam logic [4:0]  HOUR_FIRST  = 5'd1;
   localparam logic [4:0]  HOUR_MAX    = 5'd24;
   localparam logic [5:0]  MINUTE_FIRST = 6'd1;
   localparam logic [5:0]  MINUTE_MAX  = 6'd60;

   // Divide-by-100 reciprocal: q = (y * 5243) >> 19, exact for 14-bit y.
   // The low 19 product bits stay below the multiplier only when 100 | y.
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int          DIV100_SHIFT = 19;

   typedef struct packed {
      logic        command;
      logic [13:0] load_year;
      logic [3:0]  load_month;
      logic [4:0]  load_day;
      logic [4:0]  load_hour;
      logic [5:0]  load_minute;
   } req_type;

   typedef struct packed {
      logic [13:0] year_now;
      logic [3:0]  month_now;
      logic [4:0]  day_now;
      logic [4:0]  hour_now;
      logic [5:0]  minute_now;
      logic        load_rejected;
   } rsp_type;

   // Calendar state
   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
   } cal_type;

   // Days in a month; codes outside 1..12 give 31
   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
      logic [4:0] len;
      case (month) inside
         MONTH_FEB:                   len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
         default:                     len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

/* rtl/calendar_minute_clock.sv */
// Calendar minute clock top level: input register, step logic, state/result register.
// Flow: an accepted word is held in the input register, then its result in the
//   state/result register until the receiver takes it.
// Throughput: one word per cycle while results are taken; the input register takes a
//   new word while a result waits only if empty, and the step logic (one 14x13 multiply
//   per leap test) sets the cycle. Reset: synchronous, active high; clock state becomes
//   2019-01-01 01:01, both stages empty.
`include "calendar_minute_clock_assert.svh"

module calendar_minute_clock (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cmc_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cmc_pkg::rsp_type rsp_word
);

   cmc_pkg::req_type req_ff, req_in;
   logic             req_vld_ff, req_vld_in;
   cmc_pkg::cal_type cal_ff, cal_in;
   logic             rej_ff, rej_in;
   logic             rsp_vld_ff, rsp_vld_in;

   cmc_pkg::cal_type step_cal;
   logic             step_rej;
   logic             adv;
   logic             fire;
   logic             take;
   logic             time_ok;

   // Handshake: the held word moves on when the result slot is free
   assign adv       = !rsp_vld_ff || rsp_ready;
   assign fire      = req_vld_ff && adv;
   assign req_ready = !req_vld_ff || adv;
   assign take      = req_valid && req_ready;

   cmc_step u_step (
      .cur      (cal_ff),
      .req      (req_ff),
      .nxt      (step_cal),
      .rejected (step_rej)
   );

   // Next-value logic
   always_comb begin
      req_in     = take ? req_word : req_ff;
      req_vld_in = take || (req_vld_ff && !adv);
      cal_in     = fire ? step_cal : cal_ff;
      rej_in     = fire ? step_rej : rej_ff;
      rsp_vld_in = fire || (rsp_vld_ff && !rsp_ready);
   end

   // Input word register
   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   // Control and calendar state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff    <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         rej_ff        <= 1'b0;
         cal_ff.year   <= cmc_pkg::YEAR_RESET;
         cal_ff.month  <= cmc_pkg::MONTH_FIRST;
         cal_ff.day    <= cmc_pkg::DAY_FIRST;
         cal_ff.hour   <= cmc_pkg::HOUR_FIRST;
         cal_ff.minute <= cmc_pkg::MINUTE_FIRST;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         rej_ff     <= rej_in;
         cal_ff     <= cal_in;
      end
   end

   // The calendar state doubles as the result register
   assign rsp_valid              = rsp_vld_ff;
   assign rsp_word.year_now      = cal_ff.year;
   assign rsp_word.month_now     = cal_ff.month;
   assign rsp_word.day_now       = cal_ff.day;
   assign rsp_word.hour_now      = cal_ff.hour;
   assign rsp_word.minute_now    = cal_ff.minute;
   assign rsp_word.load_rejected = rej_ff;

   // Hour and minute stay one-based
   assign time_ok = (cal_ff.minute >= cmc_pkg::MINUTE_FIRST)
                 && (cal_ff.minute <= cmc_pkg::MINUTE_MAX)
                 && (cal_ff.hour >= cmc_pkg::HOUR_FIRST)
                 && (cal_ff.hour <= cmc_pkg::HOUR_MAX);

   // Checks
   `CMC_ASSERT_RESET(a_reset_empty, clock, reset, !rsp_vld_ff && !req_vld_ff)
   `CMC_ASSERT_NOW(a_time_range, clock, reset, 1'b1, time_ok)
   `CMC_ASSERT_NEXT(a_state_held, clock, reset, rsp_vld_ff && !rsp_ready, $stable(cal_ff) && $stable(rej_ff))
   `CMC_ASSERT_NEXT(a_tick_accepted, clock, reset, fire && (req_ff.command == cmc_pkg::CMD_TICK), !rej_ff && rsp_vld_ff)

endmodule

/* rtl/cmc_leap.sv */
// Gregorian leap-year test on a 14-bit year via reciprocal multiply.
module cmc_leap (
   input  logic [13:0] year,
   output logic        leap
);

   localparam int ProdW = 14 + 13;

   logic [ProdW-1:0]               prod;
   logic [cmc_pkg::DIV100_SHIFT-1:0] frac;
   logic [1:0]                     quot_lo;
   logic                           div100;

   // year * 5243: upper bits are year / 100, lower bits flag exact division
   assign prod    = ProdW'(year) * ProdW'(cmc_pkg::DIV100_MUL);
   assign frac    = prod[cmc_pkg::DIV100_SHIFT-1:0];
   assign quot_lo = prod[cmc_pkg::DIV100_SHIFT+1:cmc_pkg::DIV100_SHIFT];
   assign div100  = frac < cmc_pkg::DIV100_SHIFT'(cmc_pkg::DIV100_MUL);

   // Century years need 400 | year, i.e. 4 | (year / 100)
   assign leap = div100 ? (quot_lo == 2'd0) : (year[1:0] == 2'd0);

endmodule

/* rtl/cmc_step.sv */
// Next calendar state for one tick or load word.
module cmc_step (
   input  cmc_pkg::cal_type cur,
   input  cmc_pkg::req_type req,
   output cmc_pkg::cal_type nxt,
   output logic             rejected
);

   logic        leap_cur;
   logic        leap_ld;
   logic [13:0] ld_year;
   logic        min_c, hour_c, day_c, mon_c;
   logic        ld_ok;
   cmc_pkg::cal_type tick_val;
   cmc_pkg::cal_type load_val;

   cmc_leap u_leap_cur (.year(cur.year), .leap(leap_cur));
   cmc_leap u_leap_ld  (.year(ld_year),  .leap(leap_ld));

   // Tick: minute carry ripples through hour, day, month and year
   assign min_c  = cur.minute >= cmc_pkg::MINUTE_MAX;
   assign hour_c = min_c && (cur.hour >= cmc_pkg::HOUR_MAX);
   assign day_c  = hour_c && (cur.day >= cmc_pkg::month_len(leap_cur, cur.month));
   assign mon_c  = day_c && (cur.month >= cmc_pkg::MONTH_MAX);

   always_comb begin
      tick_val.minute = min_c ? cmc_pkg::MINUTE_FIRST : 6'(cur.minute + 6'd1);
      tick_val.hour   = !min_c ? cur.hour :
                        (hour_c ? cmc_pkg::HOUR_FIRST : 5'(cur.hour + 5'd1));
      tick_val.day    = !hour_c ? cur.day :
                        (day_c ? cmc_pkg::DAY_FIRST : 5'(cur.day + 5'd1));
      tick_val.month  = !day_c ? cur.month :
                        (mon_c ? cmc_pkg::MONTH_FIRST : 4'(cur.month + 4'd1));
      if (!mon_c) begin
         tick_val.year = cur.year;
      end else if (cur.year >= cmc_pkg::YEAR_MAX) begin
         tick_val.year = 14'd0;
      end else begin
         tick_val.year = 14'(cur.year + 14'd1);
      end
   end

   // Load: clamp the year, then range-check the other four fields
   assign ld_year = (req.load_year > cmc_pkg::YEAR_MAX) ? cmc_pkg::YEAR_MAX
                                                        : req.load_year;
   assign ld_ok = (req.load_month >= cmc_pkg::MONTH_FIRST)
               && (req.load_month <= cmc_pkg::MONTH_MAX)
               && (req.load_day >= cmc_pkg::DAY_FIRST)
               && (req.load_day <= cmc_pkg::month_len(leap_ld, req.load_month))
               && (req.load_hour >= cmc_pkg::HOUR_FIRST)
               && (req.load_hour <= cmc_pkg::HOUR_MAX)
               && (req.load_minute >= cmc_pkg::MINUTE_FIRST)
               && (req.load_minute <= cmc_pkg::MINUTE_MAX);

   always_comb begin
      load_val.year = ld_year;
      if (ld_ok) begin
         load_val.month  = req.load_month;
         load_val.day    = req.load_day;
         load_val.hour   = req.load_hour;
         load_val.minute = req.load_minute;
      end else begin
         load_val.month  = cmc_pkg::MONTH_FIRST;
         load_val.day    = cmc_pkg::DAY_FIRST;
         load_val.hour   = cmc_pkg::HOUR_FIRST;
         load_val.minute = cmc_pkg::MINUTE_FIRST;
      end
   end

   // Command select
   assign nxt      = (req.command == cmc_pkg::CMD_LOAD) ? load_val : tick_val;
   assign rejected = (req.command == cmc_pkg::CMD_LOAD) && !ld_ok;

endmodule

/* verif/tb.sv */
// Self-checking testbench for the calendar minute clock: directed carries, loads and random traffic.
`timescale 1ns / 100ps

module tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 12;
   localparam int REPORT_MAX   = 10;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   cmc_pkg::req_type req_word  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   cmc_pkg::rsp_type rsp_word;

   // Predicted calendar and the results still owed by the block
   cmc_pkg::cal_type cal_now;
   cmc_pkg::rsp_type expected_dates[$];

   // Traffic shaping
   logic idle_on      = 1'b1;
   int   hold_asks    = 0;
   int   hold_taken   = 0;
   int   hold_left    = 0;
   int   stall_left   = 0;

   // Bookkeeping
   int cycle_count   = 0;
   int error_count   = 0;
   int words_sent    = 0;
   int results_seen  = 0;
   int loads_sent    = 0;
   int loads_refused = 0;
   int year_wraps    = 0;

   calendar_minute_clock DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always #2 clock = ~clock;

   // Gregorian calendar helpers
   function automatic logic leap_year(input int y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
   endfunction

   function automatic int days_in(input int y, input int m);
      int len;
      case (m) inside
         cmc_pkg::MONTH_FEB: len = leap_year(y) ? 29 : 28;
         4, 6, 9, 11:        len = 30;
         default:            len = 31;
      endcase
      return len;
   endfunction

   // Advance the predicted calendar by one word and return the expected result
   function automatic cmc_pkg::rsp_type step_calendar(input cmc_pkg::req_type w);
      cmc_pkg::rsp_type r;
      int               y, m, d, h, mi;
      logic             ok;
      r.load_rejected = 1'b0;
      if (w.command == cmc_pkg::CMD_TICK) begin
         y  = int'(cal_now.year);
         m  = int'(cal_now.month);
         d  = int'(cal_now.day);
         h  = int'(cal_now.hour);
         mi = int'(cal_now.minute) + 1;
         if (mi > cmc_pkg::MINUTE_MAX) begin
            mi = int'(cmc_pkg::MINUTE_FIRST);
            h  = h + 1;
            if (h > cmc_pkg::HOUR_MAX) begin
               h = int'(cmc_pkg::HOUR_FIRST);
               d = d + 1;
               if (d > days_in(y, m)) begin
                  d = int'(cmc_pkg::DAY_FIRST);
                  m = m + 1;
                  if (m > cmc_pkg::MONTH_MAX) begin
                     m = int'(cmc_pkg::MONTH_FIRST);
                     if (y >= cmc_pkg::YEAR_MAX) begin
                        y = 0;
                        year_wraps++;
                     end else begin
                        y = y + 1;
                     end
                  end
               end
            end
         end
      end else begin
         loads_sent++;
         y  = (w.load_year > cmc_pkg::YEAR_MAX) ? int'(cmc_pkg::YEAR_MAX)
                                                : int'(w.load_year);
         ok = (w.load_month >= cmc_pkg::MONTH_FIRST) && (w.load_month <= cmc_pkg::MONTH_MAX)
           && (w.load_day >= cmc_pkg::DAY_FIRST)
           && (w.load_day <= days_in(y, int'(w.load_month)))
           && (w.load_hour >= cmc_pkg::HOUR_FIRST) && (w.load_hour <= cmc_pkg::HOUR_MAX)
           && (w.load_minute >= cmc_pkg::MINUTE_FIRST)
           && (w.load_minute <= cmc_pkg::MINUTE_MAX);
         if (ok) begin
            m  = int'(w.load_month);
            d  = int'(w.load_day);
            h  = int'(w.load_hour);
            mi = int'(w.load_minute);
         end else begin
            m  = int'(cmc_pkg::MONTH_FIRST);
            d  = int'(cmc_pkg::DAY_FIRST);
            h  = int'(cmc_pkg::HOUR_FIRST);
            mi = int'(cmc_pkg::MINUTE_FIRST);
            r.load_rejected = 1'b1;
            loads_refused++;
         end
      end
      cal_now.year   = 14'(y);
      cal_now.month  = 4'(m);
      cal_now.day    = 5'(d);
      cal_now.hour   = 5'(h);
      cal_now.minute = 6'(mi);
      r.year_now   = cal_now.year;
      r.month_now  = cal_now.month;
      r.day_now    = cal_now.day;
      r.hour_now   = cal_now.hour;
      r.minute_now = cal_now.minute;
      return r;
   endfunction

   function automatic cmc_pkg::req_type make_word(input logic cmd, input int y, input int m,
                                                  input int d, input int h, input int mi);
      cmc_pkg::req_type w;
      w.command     = cmd;
      w.load_year   = 14'(y);
      w.load_month  = 4'(m);
      w.load_day    = 5'(d);
      w.load_hour   = 5'(h);
      w.load_minute = 6'(mi);
      return w;
   endfunction

   // Tick with junk in the load fields
   function automatic cmc_pkg::req_type random_tick();
      return make_word(cmc_pkg::CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   // Load with every field bit random
   function automatic cmc_pkg::req_type random_load();
      return make_word(cmc_pkg::CMD_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   // Load close to a carry boundary so the ticks that follow ripple far
   function automatic cmc_pkg::req_type edge_load();
      int y, m, len;
      case ($urandom_range(0, 5))
         0:       y = int'(cmc_pkg::YEAR_MAX);
         1:       y = 2000;
         2:       y = 1900;
         3:       y = 2024;
         default: y = $urandom_range(0, cmc_pkg::YEAR_MAX);
      endcase
      m   = ($urandom_range(0, 2) == 0) ? int'(cmc_pkg::MONTH_MAX) : $urandom_range(1, 12);
      len = days_in(y, m);
      return make_word(cmc_pkg::CMD_LOAD, y, m,
                       ($urandom_range(0, 9) == 0) ? len + 1 : len - $urandom_range(0, 1),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24)
                                                   : int'(cmc_pkg::HOUR_MAX),
                       $urandom_range(50, 60));
   endfunction

   // Offer one word, with an optional idle burst first; returns after acceptance
   task automatic send_word(input cmc_pkg::req_type w);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic load_then_tick(input int y, input int m, input int d,
                                 input int h, input int mi);
      send_word(make_word(cmc_pkg::CMD_LOAD, y, m, d, h, mi));
      send_word(random_tick());
   endtask

   // Ticks straight out of reset
   task automatic test_reset_ticks();
      send_word(make_word(cmc_pkg::CMD_TICK, 0, 0, 0, 0, 0));
      send_word(make_word(cmc_pkg::CMD_TICK, 14'h3fff, 4'hf, 5'h1f, 5'h1f, 6'h3f));
   endtask

   // Carries through hour, day, month and year, leap rules included
   task automatic test_carries();
      load_then_tick(int'(cmc_pkg::YEAR_MAX), 12, 31, 24, 60);
      load_then_tick(2019, 1, 31, 24, 60);
      load_then_tick(2000, 2, 28, 24, 60);
      load_then_tick(1900, 2, 28, 24, 60);
      load_then_tick(2024, 2, 29, 24, 60);
      load_then_tick(2023, 4, 30, 5, 60);
   endtask

   // Load extremes: year clamp and each kind of bad field
   task automatic test_load_checks();
      send_word(make_word(cmc_pkg::CMD_LOAD, 14'h3fff, 12, 31, 24, 60));
      send_word(make_word(cmc_pkg::CMD_LOAD, 0, 1, 1, 1, 1));
      send_word(make_word(cmc_pkg::CMD_LOAD, 2021, 0, 5, 5, 5));
      send_word(make_word(cmc_pkg::CMD_LOAD, 2021, 13, 5, 5, 5));
      send_word(make_word(cmc_pkg::CMD_LOAD, 2021, 15, 5, 5, 5));
      send_word(make_word(cmc_pkg::CMD_LOAD, 2021, 6, 0, 5, 5));
      send_word(make_word(cmc_pkg::CMD_LOAD, 2021, 4, 31, 5, 5));
      send_word(make_word(cmc_pkg::CMD_LOAD, 2023, 2, 29, 5, 5));
      send_word(make_word(cmc_pkg::CMD_LOAD, 2000, 2, 29, 5, 5));
      send_word(make_word(cmc_pkg::CMD_LOAD, 2021, 6, 6, 0, 5));
      send_word(make_word(cmc_pkg::CMD_LOAD, 2021, 6, 6, 25, 5));
      send_word(make_word(cmc_pkg::CMD_LOAD, 2021, 6, 6, 31, 5));
      send_word(make_word(cmc_pkg::CMD_LOAD, 2021, 6, 6, 6, 0));
      send_word(make_word(cmc_pkg::CMD_LOAD, 2021, 6, 6, 6, 61));
      send_word(make_word(cmc_pkg::CMD_LOAD, 2021, 6, 6, 6, 63));
   endtask

   // Receiver stops for a long stretch while words keep coming
   task automatic test_back_pressure();
      idle_on = 1'b0;
      hold_asks++;
      repeat (40) send_word(random_tick());
      idle_on = 1'b1;
   endtask

   // Mostly ticks, seeded by loads near carry boundaries, plus random loads
   task automatic test_random_mix(input int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 12)
            send_word(edge_load());
         else if (pick < 20)
            send_word(random_load());
         else
            send_word(random_tick());
      end
   endtask

   // Closing stretch with no idling on either side
   task automatic test_full_rate();
      idle_on = 1'b0;
      test_random_mix(200);
   endtask

   // Result side: random stalls and the long hold, counted here
   always @(posedge clock) begin
      if (hold_taken != hold_asks) begin
         hold_taken <= hold_asks;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Predict on every accepted word, then check every accepted result
   always @(posedge clock) begin
      cmc_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_dates.push_back(step_calendar(req_word));
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_dates.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("unexpected result word %0d-%0d-%0d %0d:%0d rej=%0b",
                           rsp_word.year_now, rsp_word.month_now, rsp_word.day_now,
                           rsp_word.hour_now, rsp_word.minute_now, rsp_word.load_rejected);
            end else begin
               want = expected_dates.pop_front();
               if (rsp_word.year_now !== want.year_now
                   || rsp_word.month_now !== want.month_now
                   || rsp_word.day_now !== want.day_now
                   || rsp_word.hour_now !== want.hour_now
                   || rsp_word.minute_now !== want.minute_now
                   || rsp_word.load_rejected !== want.load_rejected) begin
                  error_count++;
                  if (error_count <= REPORT_MAX)
                     $display({"mismatch: expected %0d-%0d-%0d %0d:%0d rej=%0b, ",
                               "got %0d-%0d-%0d %0d:%0d rej=%0b"},
                              want.year_now, want.month_now, want.day_now,
                              want.hour_now, want.minute_now, want.load_rejected,
                              rsp_word.year_now, rsp_word.month_now, rsp_word.day_now,
                              rsp_word.hour_now, rsp_word.minute_now, rsp_word.load_rejected);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_dates.size());
         $display("FAIL calendar_minute_clock");
         $finish;
      end
   end

   // Test sequence
   initial begin
      cal_now.year   = cmc_pkg::YEAR_RESET;
      cal_now.month  = cmc_pkg::MONTH_FIRST;
      cal_now.day    = cmc_pkg::DAY_FIRST;
      cal_now.hour   = cmc_pkg::HOUR_FIRST;
      cal_now.minute = cmc_pkg::MINUTE_FIRST;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_ticks();
      test_carries();
      test_load_checks();
      test_back_pressure();
      test_random_mix(1500);
      test_full_rate();

      req_valid <= 1'b0;
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d words (%0d loads, %0d refused), checked %0d results",
               words_sent, loads_sent, loads_refused, results_seen);
      $display("year wraps seen: %0d, errors: %0d, cycles: %0d",
               year_wraps, error_count, cycle_count);
      if (error_count == 0)
         $display("PASS calendar_minute_clock");
      else
         $display("FAIL calendar_minute_clock");
      $finish;
   end

endmodule
